FILE: rtl/blbp_pkg.sv
// ----------------------------------------------------------------------------
// blbp_pkg - shared types and constants for the LCD byte packer
// Item and result beat layouts, configuration register indexes, sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package blbp_pkg;

    localparam int PIX_PER_BYTE = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;
    localparam int COORD_W      = 12;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_BIT_MODE   = 3'd0,
        CFG_IMAGE_WIDTH    = 3'd1,
        CFG_IMAGE_HEIGHT   = 3'd2,
        CFG_ORIENTATION    = 3'd3,
        CFG_PAD_MSB        = 3'd4,
        CFG_MIRROR_COLUMNS = 3'd5,
        CFG_MIRROR_ROWS    = 3'd6,
        CFG_INVERT         = 3'd7
    } t_cfg_idx;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel_x;
        logic [6:0] pixel_y;
        logic [7:0] gray_value;
        logic [7:0] byte_column;
        logic [6:0] byte_row;
    } t_item;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       in_range;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/bitmap_to_lcd_byte_packer.sv
// ----------------------------------------------------------------------------
// bitmap_to_lcd_byte_packer - gray frame store with LCD byte readout
// Stores gray pixels and packs them into monochrome or gray LCD bytes.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low. A write beat stores
// its pixel in that same cycle and gives no result; busy stays low. A read
// beat gives exactly one result, shown on o_result for one cycle with
// o_result_valid high; the receiver cannot stall it, so sample it then.
// A read outside the columns and rows in use answers on the next cycle.
// An in-range read is decoded in the cycle it is accepted, then walks the
// single-port frame store one pixel per cycle: address setup, one read per
// pixel (eight in 1-bit mode, one in gray mode) and a final step to shift
// in the last pixel; busy stays high until that step is done. Pixels never
// written read back as unknown. Write the configuration only while busy
// is low.
`default_nettype none

module bitmap_to_lcd_byte_packer
    import blbp_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_result_valid,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    // Largest sizes the width and height registers can hold
    localparam int W_SAT_I = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
    localparam int H_SAT_I = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
    localparam logic [8:0]    W_SAT     = 9'(W_SAT_I);
    localparam logic [7:0]    H_SAT     = 8'(H_SAT_I);
    localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] COL_STEP  = AW'(1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_RUN   = 3'b100
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       r_one_bit;
    logic [8:0] r_width;
    logic [7:0] r_height;
    logic [1:0] r_orient;
    logic       r_pad_msb;
    logic       r_mir_col;
    logic       r_mir_row;
    logic       r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_bit <= 1'b1;
            r_width   <= 9'd128;
            r_height  <= 8'd64;
            r_orient  <= 2'd0;
            r_pad_msb <= 1'b0;
            r_mir_col <= 1'b0;
            r_mir_row <= 1'b0;
            r_invert  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ONE_BIT_MODE: r_one_bit <= i_cfg_data[0];
                CFG_IMAGE_WIDTH: begin
                    // saturate oversized widths to the store width
                    r_width <= (i_cfg_data > W_SAT) ? W_SAT : i_cfg_data;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= (i_cfg_data[7:0] > H_SAT) ? H_SAT : i_cfg_data[7:0];
                end
                CFG_ORIENTATION:    r_orient  <= i_cfg_data[1:0];
                CFG_PAD_MSB:        r_pad_msb <= i_cfg_data[0];
                CFG_MIRROR_COLUMNS: r_mir_col <= i_cfg_data[0];
                CFG_MIRROR_ROWS:    r_mir_row <= i_cfg_data[0];
                CFG_INVERT:         r_invert  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Orientations 2 and 3 run horizontally; 0 and 2 put the first pixel in the MSB
    logic w_vertical;
    logic w_msb_first;
    assign w_vertical  = ~r_orient[1];
    assign w_msb_first = ~r_orient[0];

    // ------------------------------------------------------------------
    // Decode of an accepted beat: size in use, range check, mirroring
    // ------------------------------------------------------------------
    logic       w_accept;
    logic [8:0] w_ncols;
    logic [7:0] w_nrows;
    logic       w_in_range;
    logic [8:0] w_col;
    logic [7:0] w_row;

    assign w_accept = start & ~busy;

    always_comb begin
        if (r_one_bit && !w_vertical) begin
            w_ncols = (r_width >> 3) + 9'(|r_width[2:0]);
        end else begin
            w_ncols = r_width;
        end
        if (r_one_bit && w_vertical) begin
            w_nrows = (r_height >> 3) + 8'(|r_height[2:0]);
        end else begin
            w_nrows = r_height;
        end
        w_in_range = ({1'b0, i_item.byte_column} < w_ncols) &&
                     ({1'b0, i_item.byte_row} < w_nrows);
        w_col = r_mir_col ? (w_ncols - {1'b0, i_item.byte_column} - 9'd1)
                          : {1'b0, i_item.byte_column};
        w_row = r_mir_row ? (w_nrows - {1'b0, i_item.byte_row} - 8'd1)
                          : {1'b0, i_item.byte_row};
    end

    // ------------------------------------------------------------------
    // Address setup: first pixel position and its store address
    // ------------------------------------------------------------------
    logic [8:0]                r_col;
    logic [7:0]                r_row;
    logic [8:0]                w_size;
    logic                      w_lead;
    logic [3:0]                w_off;
    logic [8:0]                w_base;
    logic signed [COORD_W-1:0] w_p0;
    logic signed [COORD_W-1:0] w_x0;
    logic signed [COORD_W-1:0] w_y0;
    logic [31:0]               w_start_addr;

    always_comb begin
        w_size = w_vertical ? {1'b0, r_height} : r_width;
        w_lead = w_msb_first ? r_pad_msb : ~r_pad_msb;
        // pad on the leading side: shift pixels back by the missing count
        w_off  = (w_lead && (w_size[2:0] != 3'd0)) ? (4'd8 - {1'b0, w_size[2:0]}) : 4'd0;
        w_base = w_vertical ? {1'b0, r_row} : r_col;
        w_p0   = $signed({w_base, 3'b000}) - $signed({8'd0, w_off});
        if (!r_one_bit) begin
            w_x0 = $signed({3'd0, r_col});
            w_y0 = $signed({4'd0, r_row});
        end else if (w_vertical) begin
            w_x0 = $signed({3'd0, r_col});
            w_y0 = w_p0;
        end else begin
            w_x0 = w_p0;
            w_y0 = $signed({4'd0, r_row});
        end
        // modular address math: exact once the position is inside the image
        w_start_addr = {{(32-COORD_W){w_y0[COORD_W-1]}}, w_y0} * 32'(MAX_WIDTH)
                     + {{(32-COORD_W){w_x0[COORD_W-1]}}, w_x0};
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state                    r_state;
    t_state                    n_state;
    logic [2:0]                r_cnt;
    logic signed [COORD_W-1:0] r_p;
    logic [AW-1:0]             r_addr;
    logic                      w_skip;
    logic                      w_last;
    logic                      r_dv;
    logic                      r_dskip;
    logic                      r_dlast;

    // pixels before the image start or past its end are unlit padding
    assign w_skip = r_one_bit &&
                    (r_p[COORD_W-1] || (r_p[COORD_W-2:0] >= {2'b00, w_size}));
    assign w_last = !r_one_bit || (r_cnt == 3'(PIX_PER_BYTE - 1));
    assign busy   = (r_state != S_IDLE) || r_dv;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.mode == MODE_READ) && w_in_range) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = S_RUN;
            S_RUN: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == S_RUN);
        end
    end

    // Hold decoded position, advance pixel position and address per step
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept) begin
            r_col <= w_col;
            r_row <= w_row;
        end
        if (r_state == S_SETUP) begin
            r_p    <= w_p0;
            r_addr <= w_start_addr[AW-1:0];
            r_cnt  <= 3'd0;
        end else if (r_state == S_RUN) begin
            r_p    <= r_p + 12'sd1;
            r_addr <= r_addr + (w_vertical ? ROW_STEP : COL_STEP);
            r_cnt  <= r_cnt + 3'd1;
        end
        r_dskip <= w_skip;
        r_dlast <= w_last;
    end

    // ------------------------------------------------------------------
    // Frame store: single port, one write or one read per cycle
    // ------------------------------------------------------------------
    logic [7:0]  mem [DEPTH];
    logic [7:0]  r_rd_data;
    logic        w_wr_en;
    logic [31:0] w_wr_addr;

    // drop writes that fall outside the store
    assign w_wr_en = (r_state == S_IDLE) && w_accept && (i_item.mode == MODE_WRITE) &&
                     (32'(i_item.pixel_x) < 32'(MAX_WIDTH)) &&
                     (32'(i_item.pixel_y) < 32'(MAX_HEIGHT));
    assign w_wr_addr = 32'(i_item.pixel_y) * 32'(MAX_WIDTH) + 32'(i_item.pixel_x);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr[AW-1:0]] <= i_item.gray_value;
        end else if (r_state == S_RUN && !w_skip) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // ------------------------------------------------------------------
    // Bit packing: shift one lit bit per read into the byte
    // ------------------------------------------------------------------
    logic [7:0] r_acc;
    logic       w_lit;
    logic [7:0] w_acc_next;

    assign w_lit = !r_dskip && (r_invert ? (r_rd_data == 8'd0) : (r_rd_data != 8'd0));
    assign w_acc_next = w_msb_first ? {r_acc[6:0], w_lit} : {w_lit, r_acc[7:1]};

    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_acc <= w_acc_next;
        end
    end

    // Result register: out-of-range reads answer at once, others after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= (w_accept && (i_item.mode == MODE_READ) && !w_in_range) ||
                              (r_dv && r_dlast);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_accept && !w_in_range) begin
            o_result.lcd_byte <= 8'd0;
            o_result.in_range <= 1'b0;
        end else if (r_dv && r_dlast) begin
            o_result.lcd_byte <= r_one_bit ? w_acc_next : (r_rd_data ^ {8{r_invert}});
            o_result.in_range <= 1'b1;
        end
    end

endmodule

`default_nettype wire
